// ===== sv/mtf_pkg.sv =====
// Shared constants, result codes and cell control type for the move-to-front list.
`timescale 1ns / 1ps
package mtf_pkg;

  // List geometry
  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SYM_W   = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;

  // Item kinds
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Result codes
  localparam logic [STAT_W-1:0] ST_HIT      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
  localparam logic [STAT_W-1:0] ST_APPENDED = 2'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd3;

  // Per-cell update controls for one cycle
  typedef struct packed {
    logic load;       // take the incoming symbol
    logic shift;      // take the neighbour's entry
    logic set_valid;  // mark the cell as holding a list entry
  } mtf_cell_ctl_t;

endpackage

// ===== sv/move_to_front_list.sv =====
// Top level of the move-to-front list: handshake, item stages, cell chain and result register.
//
// Usage:
//   Input channel in_*: in_tuser[0] is the mode (0 append at tail, 1 look up and
//   move to front), in_tdata carries the 32-bit symbol. A transfer happens when
//   in_tvalid and in_tready are both high.
//   Result channel out_*: one result per item, out_tdata holds status in bits
//   [1:0] (0 hit, 1 miss, 2 appended, 3 dropped because full) and the hit
//   position in bits [7:2].
//   Stages: the first compares the symbol against every cell at once and
//   registers the match flags; the second finds the frontmost match, shifts
//   the chain and forms the result.
//   A new item is not taken while the previous one is still in the first stage;
//   the compare of the next item must see the chain after the previous item's shift.
//   Reset empties the list (all cell valid bits clear) and clears out_tvalid.
//   A stalled receiver holds the result; the item behind it waits in the second
//   stage and in_tready stays low until the result is taken.
`timescale 1ns / 1ps
module move_to_front_list
  import mtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] symbol
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [7:2] position
);

  // Stage registers
  logic             s1_vld_r, s1_vld_nxt;
  logic             s2_vld_r, s2_vld_nxt;
  logic             s1_mode_r, s2_mode_r;
  logic [SYM_W-1:0] s1_sym_r, s2_sym_r;
  logic             out_vld_r, out_vld_nxt;
  logic [7:0]       out_data_r;
  logic [7:0]       out_data_nxt;

  logic             in_xfer;
  logic             s2_go;

  // Cell chain signals
  logic [SYM_W-1:0] entry [DEPTH];
  logic [SYM_W-1:0] prev  [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] match;
  mtf_cell_ctl_t    ctl   [DEPTH];
  logic [SYM_W-1:0] cell_sym;

  logic             hit;
  logic [DEPTH-1:0] shift_span;
  logic [POS_W-1:0] position;
  logic             full;

  // Handshake and stage advance
  assign s2_go      = s2_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !s1_vld_r && (!s2_vld_r || s2_go);
  assign in_xfer    = in_tvalid && in_tready;
  assign s1_vld_nxt = in_xfer;
  assign s2_vld_nxt = s1_vld_r || (s2_vld_r && !s2_go);
  assign out_vld_nxt = s2_go || (out_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Item payload through the stages; hold the result until it is taken
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r <= in_tuser[0];
      s1_sym_r  <= in_tdata;
    end
    if (s1_vld_r) begin
      s2_mode_r <= s1_mode_r;
      s2_sym_r  <= s1_sym_r;
    end
    out_data_r <= out_data_nxt;
  end

  // Compare against the first-stage symbol, write with the second-stage one
  assign cell_sym = s1_vld_r ? s1_sym_r : s2_sym_r;

  // Scan the match flags
  mtf_scan u_scan (
    .match      (match),
    .hit        (hit),
    .shift_span (shift_span),
    .position   (position)
  );

  assign full = valid[DEPTH-1];

  // Drive each cell: append fills the first empty cell, a hit shifts up to it
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i] = '0;
      if (s2_go) begin
        if (s2_mode_r == MODE_APPEND) begin
          if (!valid[i] && ((i == 0) || valid[(i == 0) ? 0 : i - 1])) begin
            ctl[i].load      = 1'b1;
            ctl[i].set_valid = 1'b1;
          end
        end else begin
          ctl[i].shift = shift_span[i];
          ctl[i].load  = (i == 0) && hit;
        end
      end
    end
  end

  // Neighbour links along the chain
  always_comb begin
    prev[0] = '0;
    for (int i = 1; i < DEPTH; i++) begin
      prev[i] = entry[i-1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mtf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmp_en     (s1_vld_r),
      .sym        (cell_sym),
      .prev_entry (prev[g]),
      .ctl        (ctl[g]),
      .entry      (entry[g]),
      .valid      (valid[g]),
      .match      (match[g])
    );
  end

  // Form the result word
  always_comb begin
    out_data_nxt = out_data_r;
    if (s2_go) begin
      if (s2_mode_r == MODE_APPEND) begin
        out_data_nxt = {{POS_W{1'b0}}, (full ? ST_DROPPED : ST_APPENDED)};
      end else if (hit) begin
        out_data_nxt = {position, ST_HIT};
      end else begin
        out_data_nxt = {{POS_W{1'b0}}, ST_MISS};
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/mtf_cell.sv =====
// One list cell: holds an entry and its valid bit, compares and shifts along the chain.
`timescale 1ns / 1ps
module mtf_cell
  import mtf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmp_en,
  input  logic [SYM_W-1:0] sym,
  input  logic [SYM_W-1:0] prev_entry,
  input  mtf_cell_ctl_t    ctl,
  output logic [SYM_W-1:0] entry,
  output logic             valid,
  output logic             match
);

  logic [SYM_W-1:0] entry_r, entry_nxt;
  logic             valid_r, valid_nxt;
  logic             match_r, match_nxt;

  // Select the next entry: shift from the neighbour, load the symbol, or hold
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift) begin
      entry_nxt = prev_entry;
    end else if (ctl.load) begin
      entry_nxt = sym;
    end
    valid_nxt = valid_r | ctl.set_valid;
    match_nxt = cmp_en ? (valid_r && (entry_r == sym)) : match_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload and registered compare
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

// ===== sv/mtf_scan.sv =====
// Front-first search over the cells' match flags: hit, shift span and position.
`timescale 1ns / 1ps
module mtf_scan
  import mtf_pkg::*;
(
  input  logic [DEPTH-1:0] match,
  output logic             hit,
  output logic [DEPTH-1:0] shift_span,
  output logic [POS_W-1:0] position
);

  logic [DEPTH-1:0] ahead;
  logic [DEPTH-1:0] first;
  logic [IDX_W-1:0] idx;

  // Flag any match in front of each cell, then keep the frontmost match only
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ahead[i] = |(match & ((DEPTH'(1) << i) - DEPTH'(1)));
    end
    first = match & ~ahead;
    hit   = |match;
  end

  // Cells from index 1 up to the hit take their neighbour's entry
  always_comb begin
    shift_span = '0;
    for (int i = 1; i < DEPTH; i++) begin
      shift_span[i] = hit & ~ahead[i];
    end
  end

  // Encode the one-hot first match; the position field is as wide as the index
  always_comb begin
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      idx = idx | (first[i] ? IDX_W'(i) : IDX_W'(0));
    end
    position = POS_W'(idx);
  end

endmodule
